// ===== hdl/timestamp_gap_monitor_defines.svh =====
// ----------------------------------------------------------------------------
// timestamp_gap_monitor_defines
// Assertion macros shared by the timestamp gap monitor RTL.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_GAP_MONITOR_DEFINES_SVH
`define TIMESTAMP_GAP_MONITOR_DEFINES_SVH

`ifndef ASSERT_OFF
// expr must hold at every clock edge out of reset
`define TGM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
// ante at one edge implies cons at the next edge
`define TGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TGM_ASSERT_ALWAYS(lbl, expr, msg)
`define TGM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/tgm_pkg.sv =====
// ----------------------------------------------------------------------------
// tgm_pkg
// Types and constants for the timestamp gap monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package tgm_pkg;

  localparam int unsigned RECORD_INTERVALS = 512;
  localparam int unsigned REC_CNT_W        = $clog2(RECORD_INTERVALS + 1);

  localparam int unsigned CFG_IDX_W = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAP_THRESHOLD    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CREDIT_PER_GAP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_LIMIT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_ON_BUSY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CALIBRATE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_ENABLE    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SECOND_TICKS = 3'd6;

  // register reset values
  localparam logic [31:0] GAP_THRESHOLD_RST    = 32'd200;
  localparam logic [31:0] ONE_SECOND_TICKS_RST = 32'd1000000000;

  // status codes
  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_LIMIT   = 3'd1;
  localparam logic [2:0] ST_STOPPED = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CALFAIL = 3'd4;
  localparam logic [2:0] ST_IDLE    = 3'd5;

  typedef struct packed {
    logic [31:0] gap_threshold;
    logic [31:0] credit_per_gap;
    logic [63:0] run_limit;
    logic        stop_on_busy;
    logic        calibrate;
    logic        record_enable;
    logic [31:0] one_second_ticks;
  } tgm_cfg_t;

  typedef struct packed {
    logic [63:0] stamp;
    logic        start_req;
    logic        stop_request;
  } tgm_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] busy_total;
    logic [63:0] largest_gap;
    logic [63:0] smallest_step;
    logic [31:0] stall_count;
    logic        gap_valid;
    logic [63:0] gap_begin;
    logic [63:0] gap_end;
    logic [63:0] elapsed;
  } tgm_out_t;

endpackage

`default_nettype wire

// ===== hdl/tgm_cfg.sv =====
// ----------------------------------------------------------------------------
// tgm_cfg
// Configuration register file; writes are registered and always accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module tgm_cfg
  import tgm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data,
  output tgm_cfg_t                  cfg
);

  tgm_cfg_t cfg_r, cfg_nxt;
  logic     wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (cfg_index)
        REG_GAP_THRESHOLD:    cfg_nxt.gap_threshold    = cfg_data[31:0];
        REG_CREDIT_PER_GAP:   cfg_nxt.credit_per_gap   = cfg_data[31:0];
        REG_RUN_LIMIT:        cfg_nxt.run_limit        = cfg_data;
        REG_STOP_ON_BUSY:     cfg_nxt.stop_on_busy     = cfg_data[0];
        REG_CALIBRATE:        cfg_nxt.calibrate        = cfg_data[0];
        REG_RECORD_ENABLE:    cfg_nxt.record_enable    = cfg_data[0];
        REG_ONE_SECOND_TICKS: cfg_nxt.one_second_ticks = cfg_data[31:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_threshold    <= GAP_THRESHOLD_RST;
      cfg_r.credit_per_gap   <= '0;
      cfg_r.run_limit        <= '0;
      cfg_r.stop_on_busy     <= 1'b0;
      cfg_r.calibrate        <= 1'b0;
      cfg_r.record_enable    <= 1'b0;
      cfg_r.one_second_ticks <= ONE_SECOND_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tgm_core.sv =====
// ----------------------------------------------------------------------------
// tgm_core
// Trial state and combinational step update; res is the result for item and
// the state advances on fire.
// ----------------------------------------------------------------------------
`default_nettype none

module tgm_core
  import tgm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tgm_cfg_t cfg,
  input  wire logic     fire,
  input  wire tgm_in_t  item,
  output tgm_out_t      res
);

  logic                 active_r, active_nxt;
  logic [63:0]          begin_r, begin_nxt;
  logic [63:0]          prev_r, prev_nxt;
  logic [63:0]          busy_r, busy_nxt;
  logic [63:0]          max_r, max_nxt;
  logic [63:0]          min_r, min_nxt;
  logic [31:0]          cnt_r, cnt_nxt;
  logic [REC_CNT_W-1:0] rec_r, rec_nxt;

  logic [63:0] ost_ext;
  logic [63:0] diff;
  logic [63:0] elapsed_val;
  logic        is_stall;
  logic [63:0] add_val;
  logic [64:0] sum;
  logic [63:0] busy_step;
  logic        rec_room;
  logic        full;
  logic        limit_hit;

  // pre-finish values and end-of-trial control
  logic [63:0] busy_pre;
  logic [63:0] min_pre;
  logic        end_trial;
  logic [2:0]  reason;
  logic [2:0]  status;

  assign ost_ext     = {32'd0, cfg.one_second_ticks};
  assign diff        = item.stamp - prev_r;
  assign elapsed_val = item.stamp - begin_r;
  assign is_stall    = diff > {32'd0, cfg.gap_threshold};
  assign add_val     = is_stall ? {32'd0, cfg.credit_per_gap} : diff;
  assign sum         = {1'b0, busy_r} + {1'b0, add_val};
  assign busy_step   = sum[64] ? '1 : sum[63:0];
  assign rec_room    = rec_r < REC_CNT_W'(RECORD_INTERVALS);
  assign full        = is_stall && cfg.record_enable && !rec_room;
  assign limit_hit   = cfg.stop_on_busy ? (busy_step >= cfg.run_limit)
                                        : (elapsed_val > cfg.run_limit);

  always_comb begin
    active_nxt = active_r;
    begin_nxt  = begin_r;
    prev_nxt   = prev_r;
    busy_pre   = busy_r;
    max_nxt    = max_r;
    min_pre    = min_r;
    cnt_nxt    = cnt_r;
    rec_nxt    = rec_r;
    end_trial  = 1'b0;
    reason     = ST_IDLE;
    res        = '0;
    res.status = ST_IDLE;

    if (item.start_req) begin
      active_nxt = 1'b1;
      begin_nxt  = item.stamp;
      prev_nxt   = cfg.calibrate ? item.stamp - ost_ext : item.stamp;
      busy_pre   = '0;
      max_nxt    = '0;
      min_pre    = ost_ext;
      cnt_nxt    = '0;
      rec_nxt    = '0;
      reason     = ST_RUNNING;
      if (item.stop_request) begin
        end_trial = 1'b1;
        reason    = ST_STOPPED;
      end
    end else if (active_r) begin
      if (item.stop_request) begin
        end_trial   = 1'b1;
        reason      = ST_STOPPED;
        res.elapsed = elapsed_val;
      end else begin
        prev_nxt = item.stamp;
        busy_pre = busy_step;
        reason   = ST_RUNNING;
        if (is_stall) begin
          if (cnt_r != '1) begin
            cnt_nxt = cnt_r + 32'd1;
          end
          if (diff > max_r) begin
            max_nxt = diff;
          end
          if (cfg.record_enable && rec_room) begin
            rec_nxt       = rec_r + REC_CNT_W'(1);
            res.gap_valid = 1'b1;
            res.gap_begin = prev_r;
            res.gap_end   = item.stamp;
          end
        end else if (diff < min_r) begin
          min_pre = diff;
        end
        // storage full wins over the limit check
        if (full) begin
          end_trial   = 1'b1;
          reason      = ST_FULL;
          res.elapsed = elapsed_val;
        end else if (limit_hit) begin
          end_trial   = 1'b1;
          reason      = ST_LIMIT;
          res.elapsed = elapsed_val;
        end
      end
    end

    status   = reason;
    busy_nxt = busy_pre;
    min_nxt  = min_pre;
    if (end_trial) begin
      active_nxt = 1'b0;
      if (cfg.calibrate && min_pre == ost_ext) begin
        status = ST_CALFAIL;
      end
      if (!cfg.stop_on_busy && busy_pre > cfg.run_limit) begin
        busy_nxt = cfg.run_limit;
      end
    end

    if (item.start_req || active_r) begin
      res.status = status;
    end
    res.busy_total    = busy_nxt;
    res.largest_gap   = max_nxt;
    res.smallest_step = min_nxt;
    res.stall_count   = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      begin_r  <= '0;
      prev_r   <= '0;
      busy_r   <= '0;
      max_r    <= '0;
      min_r    <= '0;
      cnt_r    <= '0;
      rec_r    <= '0;
    end else if (fire) begin
      active_r <= active_nxt;
      begin_r  <= begin_nxt;
      prev_r   <= prev_nxt;
      busy_r   <= busy_nxt;
      max_r    <= max_nxt;
      min_r    <= min_nxt;
      cnt_r    <= cnt_nxt;
      rec_r    <= rec_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/timestamp_gap_monitor.sv =====
// ----------------------------------------------------------------------------
// timestamp_gap_monitor
// Stall detector over a stream of timestamp samples.
// ----------------------------------------------------------------------------
// Takes one timestamp sample per transfer and returns one result per sample,
// in order. Throughput is one sample per clock while out_stall is low; samples
// pass the input register, then the result register. The rate is set by the
// trial-state update loop in tgm_core: subtract, stall compare, saturating
// accumulate and limit compare are combinational, so each sample sees the
// state left by the one before it. Configuration writes are always accepted
// and take effect on the next clock; write them while no sample is in flight.
`default_nettype none

`include "timestamp_gap_monitor_defines.svh"

module timestamp_gap_monitor
  import tgm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire tgm_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output tgm_out_t                  out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [63:0]          cfg_data
);

  tgm_cfg_t cfg;
  tgm_out_t res;

  logic     in_v_r, in_v_nxt;
  tgm_in_t  in_item_r;
  logic     out_v_r, out_v_nxt;
  tgm_out_t out_item_r;
  logic     move;
  logic     in_xfer;

  tgm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tgm_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .fire  (move),
    .item  (in_item_r),
    .res   (res)
  );

  // item leaves the input register when the result register is free or drains
  assign move     = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !move;
  assign in_xfer  = in_valid && !in_stall;

  assign in_v_nxt  = in_xfer ? 1'b1 : (move ? 1'b0 : in_v_r);
  assign out_v_nxt = move ? 1'b1 : (out_stall ? out_v_r : 1'b0);

  assign out_valid = out_v_r;
  assign out_data  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r <= in_data;
    end
    if (move) begin
      out_item_r <= res;
    end
  end

  `TGM_ASSERT_NEXT(a_in_hold, in_v_r && !move, in_v_r && $stable(in_item_r), "input item lost")
  `TGM_ASSERT_ALWAYS(a_gap_status, !(out_v_r && out_item_r.gap_valid) || (out_item_r.status != ST_IDLE && out_item_r.status != ST_STOPPED), "gap recorded on idle or stop item")
  `TGM_ASSERT_ALWAYS(a_gap_count, !(out_v_r && out_item_r.gap_valid) || (out_item_r.stall_count != '0), "gap recorded without stall count")

endmodule

`default_nettype wire
